// ----- hdl/i2r_pkg.sv -----
// Shared types, constants and numeral helper functions for the
// integer-to-Roman-numeral block. No dependencies.
package i2r_pkg;

  localparam int VALUE_W    = 12;
  localparam int CODE_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_PLACES = 4;
  localparam int REST_W     = 14;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(3999);
  localparam logic [CODE_W-1:0]  CHAR_NUL  = 8'h00;

  typedef logic [1:0]                    place_t;
  typedef logic [1:0]                    pos_t;
  typedef logic [DIGIT_W-1:0]            digit_t;
  typedef digit_t [NUM_PLACES-1:0]       digits_t;

  // Place index 0 holds thousands, index 3 holds units.
  localparam place_t PLACE_THOUSANDS = 2'd0;
  localparam place_t PLACE_HUNDREDS  = 2'd1;
  localparam place_t PLACE_TENS      = 2'd2;
  localparam place_t PLACE_UNITS     = 2'd3;

  typedef struct packed {
    logic    push;
    digits_t digits;
  } q_wr_t;

  typedef struct packed {
    logic    valid;
    digits_t digits;
  } q_rd_t;

  typedef enum logic {FR_IDLE, FR_CONV}  front_state_t;
  typedef enum logic {BK_CHARS, BK_TERM} back_state_t;
  typedef enum logic [1:0] {SEL_ONE, SEL_FIVE, SEL_TEN} sym_sel_t;

  // Value of digit d at place p, used as the greedy threshold.
  function automatic logic [REST_W-1:0] thresh(place_t p, int unsigned d);
    logic [REST_W-1:0] t;
    case (p)
      PLACE_THOUSANDS: t = REST_W'(d * 1000);
      PLACE_HUNDREDS:  t = REST_W'(d * 100);
      PLACE_TENS:      t = REST_W'(d * 10);
      default:         t = REST_W'(d);
    endcase
    return t;
  endfunction

  // Number of characters that one decimal digit needs.
  function automatic logic [2:0] digit_len(digit_t d);
    logic [2:0] n;
    case (d)
      4'd1, 4'd5:       n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:             n = 3'd2;
      4'd3, 4'd7:       n = 3'd3;
      4'd8:             n = 3'd4;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  // Which of the place's three symbols stands at position pos of digit d.
  function automatic sym_sel_t pat_sel(digit_t d, pos_t pos);
    sym_sel_t s;
    s = SEL_ONE;
    if (d inside {[4'd5:4'd8]}) begin
      s = (pos == 2'd0) ? SEL_FIVE : SEL_ONE;
    end else if (d == 4'd4) begin
      s = (pos == 2'd0) ? SEL_ONE : SEL_FIVE;
    end else if (d == 4'd9) begin
      s = (pos == 2'd0) ? SEL_ONE : SEL_TEN;
    end
    return s;
  endfunction

  function automatic logic [CODE_W-1:0] sym_char(place_t p, sym_sel_t s);
    logic [CODE_W-1:0] c;
    c = CHAR_NUL;
    case (p)
      PLACE_THOUSANDS: c = "M";
      PLACE_HUNDREDS: begin
        case (s)
          SEL_ONE:  c = "C";
          SEL_FIVE: c = "D";
          SEL_TEN:  c = "M";
          default:  c = CHAR_NUL;
        endcase
      end
      PLACE_TENS: begin
        case (s)
          SEL_ONE:  c = "X";
          SEL_FIVE: c = "L";
          SEL_TEN:  c = "C";
          default:  c = CHAR_NUL;
        endcase
      end
      default: begin
        case (s)
          SEL_ONE:  c = "I";
          SEL_FIVE: c = "V";
          SEL_TEN:  c = "X";
          default:  c = CHAR_NUL;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/i2r_front.sv -----
// Front end: accepts an integer, saturates it and splits it into four
// decimal digits, one place per cycle, the units place waiting while the queue is full. Depends on i2r_pkg.
module i2r_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [i2r_pkg::VALUE_W-1:0]   in_value,
  input  logic                          q_full,
  output i2r_pkg::q_wr_t                q_wr
);
  import i2r_pkg::*;

  front_state_t      state_r, state_nxt;
  logic [REST_W-1:0] rest_r, rest_nxt;
  place_t            place_r, place_nxt;
  digits_t           digits_r, digits_nxt;
  digit_t            digit;
  logic [REST_W-1:0] sub;
  logic [VALUE_W-1:0] sat_value;

  assign sat_value = (in_value > VALUE_MAX) ? VALUE_MAX : in_value;
  assign in_stall  = (state_r != FR_IDLE);

  // Largest digit whose value does not exceed the remainder.
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int d = 1; d <= 9; d++) begin
      if (rest_r >= thresh(place_r, d)) begin
        digit = DIGIT_W'(d);
        sub   = thresh(place_r, d);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rest_nxt    = rest_r;
    place_nxt   = place_r;
    digits_nxt  = digits_r;
    q_wr.push   = 1'b0;
    q_wr.digits = digits_r;
    q_wr.digits[PLACE_UNITS] = digit;
    case (state_r)
      FR_IDLE: begin
        if (in_valid) begin
          rest_nxt  = REST_W'(sat_value);
          place_nxt = PLACE_THOUSANDS;
          state_nxt = FR_CONV;
        end
      end
      FR_CONV: begin
        if (place_r != PLACE_UNITS) begin
          digits_nxt[place_r] = digit;
          rest_nxt            = rest_r - sub;
          place_nxt           = place_r + 2'd1;
        end else if (!q_full) begin
          q_wr.push = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rest_r   <= rest_nxt;
    place_r  <= place_nxt;
    digits_r <= digits_nxt;
  end

endmodule

// ----- hdl/i2r_fifo.sv -----
// Short queue of digit words between the front end and the emitter.
// Depends on i2r_pkg.
module i2r_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  i2r_pkg::q_wr_t q_wr,
  output logic           q_full,
  input  logic           q_pop,
  output i2r_pkg::q_rd_t q_rd
);
  import i2r_pkg::*;

  digits_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;
  logic                do_push, do_pop;

  assign q_full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_rd.valid  = (count_r != '0);
  assign q_rd.digits = mem_r[rd_ptr_r];
  assign do_push     = q_wr.push && !q_full;
  assign do_pop      = q_pop && q_rd.valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.digits;
    end
  end

endmodule

// ----- hdl/i2r_back.sv -----
// Emitter: walks the four places of the queued digit word and sends one
// numeral character per transfer, then the terminator. Depends on i2r_pkg.
module i2r_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  i2r_pkg::q_rd_t              q_rd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [i2r_pkg::CODE_W-1:0]  out_char_code,
  output logic                        out_last
);
  import i2r_pkg::*;

  back_state_t       state_r, state_nxt;
  place_t            place_r, place_nxt;
  pos_t              pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_char_code_r, out_char_code_nxt;
  logic              out_last_r, out_last_nxt;
  logic              load;
  digit_t            digit;
  logic [2:0]        len;

  assign load  = !out_valid_r || !out_stall;
  assign digit = q_rd.digits[place_r];
  assign len   = digit_len(digit);

  always_comb begin
    state_nxt         = state_r;
    place_nxt         = place_r;
    pos_nxt           = pos_r;
    out_valid_nxt     = out_valid_r;
    out_char_code_nxt = out_char_code_r;
    out_last_nxt      = out_last_r;
    q_pop             = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b0;
      if (q_rd.valid) begin
        case (state_r)
          BK_CHARS: begin
            if ({1'b0, pos_r} < len) begin
              out_valid_nxt     = 1'b1;
              out_char_code_nxt = sym_char(place_r, pat_sel(digit, pos_r));
              out_last_nxt      = 1'b0;
            end
            // Step to the next place after the digit's last character, or
            // straight away when the digit is zero.
            if ({1'b0, pos_r} + 3'd1 >= len) begin
              pos_nxt = '0;
              if (place_r == PLACE_UNITS) begin
                state_nxt = BK_TERM;
              end else begin
                place_nxt = place_r + 2'd1;
              end
            end else begin
              pos_nxt = pos_r + 2'd1;
            end
          end
          BK_TERM: begin
            out_valid_nxt     = 1'b1;
            out_char_code_nxt = CHAR_NUL;
            out_last_nxt      = 1'b1;
            q_pop             = 1'b1;
            state_nxt         = BK_CHARS;
            place_nxt         = PLACE_THOUSANDS;
            pos_nxt           = '0;
          end
          default: state_nxt = BK_CHARS;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CHARS;
      place_r     <= PLACE_THOUSANDS;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      place_r     <= place_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_code_r <= out_char_code_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_code_r;
  assign out_last      = out_last_r;

endmodule

// ----- hdl/integer_to_roman_numeral.sv -----
// Integer to Roman numeral converter, top level.
// Input channel: in_valid, in_stall, in_value (0..3999; larger values
// are treated as 3999). A transfer takes place when in_valid is high and
// in_stall is low.
// Output channel: out_valid, out_stall, out_char_code, out_last. Each value
// gives its numeral as ASCII characters, most significant first, followed by
// one NUL character with out_last set; zero gives the NUL alone.
// The front end takes one value, splits it into decimal digits one place at
// a time and queues the digit word in a two-entry queue; it takes
// the next value once that word is queued. The emitter sends one character
// per cycle from a registered output while out_stall is low, and emits
// nothing while it steps past a zero digit. The length of each numeral and
// its zero digits set how long it occupies the emitter, and the
// output channel sets the sustained rate. An input value reaches out_valid
// through the front end's digit split, the queue and the output register;
// each leading zero digit delays the first character further.
// Holding out_stall freezes the output register; the queue then fills and
// in_stall rises. Synchronous reset (rst_n low) empties the queue and drops
// out_valid; no clearing pass is needed.
module integer_to_roman_numeral (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [i2r_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [i2r_pkg::CODE_W-1:0]  out_char_code,
  output logic                        out_last
);
  import i2r_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  i2r_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  i2r_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  i2r_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rd          (q_rd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  a_term_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_char_code == CHAR_NUL)
    else $error("terminator carries a non-NUL character");

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front end ready again straight after an input transfer");

  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> q_rd.valid)
    else $error("queue full but shows no entry");

  a_pop_only_term: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_rd.valid |=> out_valid && out_last)
    else $error("queue entry retired without a terminator");

endmodule
